@@ hdl/color_style_preset_blend_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the colour style preset blend core
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef COLOR_STYLE_PRESET_BLEND_CORE_DEFINES_SVH
`define COLOR_STYLE_PRESET_BLEND_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Hold the property at every clock edge outside reset.
`define CSPB_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
// Require the consequent in the cycle after the antecedent.
`define CSPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define CSPB_ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define CSPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/csb_pkg.sv @@
// ---------------------------------------------------------------------------
// Colour style preset blend package
// Beat types, preset codes, fixed-point gains and coefficient lookup.
// ---------------------------------------------------------------------------
package csb_pkg;

  // Input and output beats
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } csb_pix_in_t;

  typedef struct packed {
    logic [8:0] red_out;
    logic [8:0] green_out;
    logic [8:0] blue_out;
    logic [7:0] alpha_out;
  } csb_pix_out_t;

  // Styled colour in 1/256 of a pixel step
  localparam int unsigned STYLED_W = 17;

  typedef struct packed {
    logic [2:0][STYLED_W-1:0] styled;
    logic [2:0][7:0]          pix;
    logic [7:0]               alpha;
  } csb_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } csb_q_status_t;

  // Channel positions
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WEIGHT = 8'd1;

  typedef enum logic [2:0] {
    PRESET_WARM   = 3'd0,
    PRESET_ROTATE = 3'd1,
    PRESET_COOL   = 3'd2,
    PRESET_SWAP   = 3'd3,
    PRESET_VIVID  = 3'd4,
    PRESET_GREY   = 3'd5
  } csb_preset_e;

  // Gains rounded to 1/256
  localparam logic [8:0] GAIN_1P3 = 9'd333;
  localparam logic [8:0] GAIN_0P7 = 9'd179;
  localparam logic [8:0] GAIN_1P4 = 9'd358;
  localparam logic [8:0] GAIN_0P5 = 9'd128;
  localparam logic [8:0] GAIN_0P9 = 9'd230;
  localparam logic [8:0] GAIN_1P5 = 9'd384;
  localparam logic [8:0] GAIN_1P2 = 9'd307;
  localparam logic [8:0] GAIN_0P8 = 9'd205;
  localparam logic [8:0] GAIN_0P2 = 9'd51;
  localparam logic [8:0] GAIN_1P8 = 9'd461;
  localparam logic [8:0] LUM_R    = 9'd77;
  localparam logic [8:0] LUM_G    = 9'd150;
  localparam logic [8:0] LUM_B    = 9'd29;
  localparam logic [8:0] ONE_Q8   = 9'd256;

  localparam logic [13:0] OFS_0P1 = 14'd6528;
  localparam logic [13:0] OFS_0P2 = 14'd13056;

  localparam logic [8:0]  SAT_MAX    = 9'd510;
  localparam logic [26:0] ROUND_HALF = 27'd32768;

  // Weight of input channel ic in output channel oc under a preset
  function automatic logic [8:0] csb_coef(input logic [2:0] preset,
                                          input logic [1:0] oc,
                                          input logic [1:0] ic);
    logic [8:0] k;
    logic       diag;
    k    = '0;
    diag = (oc == ic);
    case (csb_preset_e'(preset))
      PRESET_WARM: begin
        if (diag) k = (oc == CH_R) ? GAIN_1P3 : (oc == CH_G) ? GAIN_0P7 : GAIN_1P4;
      end
      PRESET_ROTATE: begin
        if ((oc == CH_R && ic == CH_B) || (oc == CH_G && ic == CH_R) ||
            (oc == CH_B && ic == CH_G)) k = ONE_Q8;
      end
      PRESET_COOL: begin
        if (diag) k = (oc == CH_R) ? GAIN_0P5 : (oc == CH_G) ? GAIN_0P9 : GAIN_1P5;
      end
      PRESET_SWAP: begin
        if (oc == CH_R && ic == CH_G) k = GAIN_1P2;
        if (oc == CH_G && ic == CH_R) k = GAIN_0P8;
        if (oc == CH_B && ic == CH_B) k = GAIN_0P9;
      end
      PRESET_VIVID: begin
        if (diag) k = (oc == CH_R) ? GAIN_1P5 : (oc == CH_G) ? GAIN_0P2 : GAIN_1P8;
      end
      PRESET_GREY: begin
        k = (ic == CH_R) ? LUM_R : (ic == CH_G) ? LUM_G : LUM_B;
      end
      default: begin
        if (diag) k = ONE_Q8;
      end
    endcase
    return k;
  endfunction

  // Constant term of output channel oc under a preset
  function automatic logic [13:0] csb_ofs(input logic [2:0] preset,
                                          input logic [1:0] oc);
    logic [13:0] o;
    o = '0;
    if (csb_preset_e'(preset) == PRESET_VIVID) begin
      if (oc == CH_R) o = OFS_0P1;
      if (oc == CH_B) o = OFS_0P2;
    end
    return o;
  endfunction

endpackage

@@ hdl/csb_front.sv @@
// ---------------------------------------------------------------------------
// Colour style preset blend: front end
// Accept pixel beats, form the styled colour and hand entries to the queue.
// ---------------------------------------------------------------------------
module csb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [2:0]             preset_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  csb_pkg::csb_pix_in_t   in_data_i,
  input  csb_pkg::csb_q_status_t q_status_i,
  output logic                   push_o,
  output csb_pkg::csb_entry_t    entry_o
);
  import csb_pkg::*;

  logic             valid_q, valid_d;
  csb_entry_t       entry_q, entry_d;
  logic [2:0][7:0]  chan;
  logic             accept;

  assign chan[CH_R] = in_data_i.red_in;
  assign chan[CH_G] = in_data_i.green_in;
  assign chan[CH_B] = in_data_i.blue_in;

  // Forward the held entry whenever the queue has room
  assign push_o     = valid_q && !q_status_i.full;
  assign in_ready_o = !valid_q || push_o;
  assign accept     = in_valid_i && in_ready_o;

  for (genvar oc = 0; oc < 3; oc++) begin : g_styled
    logic [17:0] acc;
    assign acc = 18'(chan[CH_R]) * 18'(csb_coef(preset_i, 2'(oc), CH_R))
               + 18'(chan[CH_G]) * 18'(csb_coef(preset_i, 2'(oc), CH_G))
               + 18'(chan[CH_B]) * 18'(csb_coef(preset_i, 2'(oc), CH_B))
               + 18'(csb_ofs(preset_i, 2'(oc)));
    assign entry_d.styled[oc] = acc[STYLED_W-1:0];
  end

  assign entry_d.pix   = chan;
  assign entry_d.alpha = in_data_i.alpha_in;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ hdl/csb_queue.sv @@
// ---------------------------------------------------------------------------
// Colour style preset blend: entry queue
// Small circular queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`include "color_style_preset_blend_core_defines.svh"

module csb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  csb_pkg::csb_entry_t    entry_i,
  input  logic                   pop_i,
  output csb_pkg::csb_entry_t    entry_o,
  output csb_pkg::csb_q_status_t status_o
);
  import csb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  csb_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign entry_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `CSPB_ASSERT_ALWAYS(a_no_pop_when_empty, clk_i, rst_ni, !(pop_i && (cnt_q == '0)))
  `CSPB_ASSERT_NEXT(a_push_leaves_entry, clk_i, rst_ni, push_i && !pop_i, cnt_q != '0)
  `CSPB_ASSERT_NEXT(a_pop_drops_one, clk_i, rst_ni, pop_i && !push_i, cnt_q + 1'b1 == $past(cnt_q))

endmodule

@@ hdl/csb_back.sv @@
// ---------------------------------------------------------------------------
// Colour style preset blend: back end
// Mix each entry toward its styled colour, round, saturate, register.
// ---------------------------------------------------------------------------
module csb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [8:0]             weight_i,
  input  csb_pkg::csb_q_status_t q_status_i,
  input  csb_pkg::csb_entry_t    entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output csb_pkg::csb_pix_out_t  out_data_o
);
  import csb_pkg::*;

  logic            valid_q, valid_d;
  csb_pix_out_t    data_q, data_d;
  logic [8:0]      inv_w;
  logic [2:0][8:0] mixed;

  // Pull an entry whenever the output register is free or being drained
  assign pop_o = !q_status_i.empty && (!valid_q || out_ready_i);
  assign inv_w = ONE_Q8 - weight_i;

  for (genvar c = 0; c < 3; c++) begin : g_mix
    logic [24:0] keep_term;
    logic [25:0] style_term;
    logic [26:0] acc;
    logic [10:0] rounded;
    assign keep_term  = 25'({entry_i.pix[c], 8'd0}) * 25'(inv_w);
    assign style_term = 26'(entry_i.styled[c]) * 26'(weight_i);
    assign acc        = 27'(keep_term) + 27'(style_term) + ROUND_HALF;
    assign rounded    = acc[26:16];
    assign mixed[c]   = (rounded > 11'(SAT_MAX)) ? SAT_MAX : rounded[8:0];
  end

  always_comb begin
    data_d.red_out   = mixed[CH_R];
    data_d.green_out = mixed[CH_G];
    data_d.blue_out  = mixed[CH_B];
    data_d.alpha_out = entry_i.alpha;
  end

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ hdl/color_style_preset_blend_core.sv @@
// ---------------------------------------------------------------------------
// Colour style preset blend core
// Per-pixel colour styling by preset, mixed with the input by a weight.
// ---------------------------------------------------------------------------
// Takes one RGBA pixel beat per clock and returns one result beat per pixel,
// in order. Sustained rate is one pixel per clock while the result channel
// does not stall. The beat passes three register stages (front register,
// queue, output register); the front register loads at the accepting edge,
// then the queue and the output register take it in turn, in that order. The
// front end forms the styled colour as a 3x3 gain matrix plus offset in
// 1/256 steps; the back end mixes input and styled colour by the weight
// (clamped to 256), rounds half up and saturates at 510. Alpha is carried
// unchanged. The configuration port is always ready: index 0 is the preset
// (3 bits), index 1 the weight (9 bits); writes to other indexes are
// dropped. Write configuration only while no pixel is in flight.
// ---------------------------------------------------------------------------
module color_style_preset_blend_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [csb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [8:0]                       cfg_data_i,
  // pixel input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  csb_pkg::csb_pix_in_t             in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output csb_pkg::csb_pix_out_t            out_data_o
);
  import csb_pkg::*;

  logic [2:0]    preset_q, preset_d;
  logic [8:0]    weight_q, weight_d;
  logic [8:0]    weight_clamped;
  logic          push, pop;
  csb_entry_t    push_entry, pop_entry;
  csb_q_status_t q_status;

  // Configuration registers take every write beat at once
  assign cfg_ready_o = 1'b1;

  always_comb begin
    preset_d = preset_q;
    weight_d = weight_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_PRESET: preset_d = cfg_data_i[2:0];
        CFG_IDX_WEIGHT: weight_d = cfg_data_i;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q <= 3'(PRESET_WARM);
      weight_q <= ONE_Q8;
    end else begin
      preset_q <= preset_d;
      weight_q <= weight_d;
    end
  end

  // Weights above 1.0 act as 1.0
  assign weight_clamped = (weight_q > ONE_Q8) ? ONE_Q8 : weight_q;

  // Front: accept pixel beat, build styled colour, hold it until queued
  csb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .preset_i   (preset_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue: lets front and back stall on their own
  csb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  // Back: blend, round, saturate into the output register
  csb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weight_i    (weight_clamped),
    .q_status_i  (q_status),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ bench/tb_color_style_preset_blend_core.sv @@
// ---------------------------------------------------------------------------
// Testbench for the colour style preset blend core
// Drives pixel beats and configuration writes, predicts every result beat
// from a local copy of the preset and weight, and checks each field in order.
// ---------------------------------------------------------------------------
module tb_color_style_preset_blend_core;
  import csb_pkg::*;

  // Own copy of the fixed-point gains, kept apart from the package on purpose
  localparam int unsigned K_1P3 = 333;
  localparam int unsigned K_0P7 = 179;
  localparam int unsigned K_1P4 = 358;
  localparam int unsigned K_0P5 = 128;
  localparam int unsigned K_0P9 = 230;
  localparam int unsigned K_1P5 = 384;
  localparam int unsigned K_1P2 = 307;
  localparam int unsigned K_0P8 = 205;
  localparam int unsigned K_0P2 = 51;
  localparam int unsigned K_1P8 = 461;
  localparam int unsigned K_LUM_R = 77;
  localparam int unsigned K_LUM_G = 150;
  localparam int unsigned K_LUM_B = 29;
  localparam int unsigned K_UNITY = 256;
  localparam int unsigned K_OFS_TENTH = 6528;
  localparam int unsigned K_OFS_FIFTH = 13056;
  localparam int unsigned K_CLIP = 510;

  // Index with no register behind it; the core drops such writes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;

  // Presets six and seven have no name in the package: both pass the colour
  localparam logic [2:0] PRESET_PASS_A = 3'd6;
  localparam logic [2:0] PRESET_PASS_B = 3'd7;

  localparam int unsigned IDLE_PCT     = 17;
  localparam int unsigned PIPE_SLACK   = 8;
  localparam int unsigned LIMIT_CYCLES = 250000;
  localparam int unsigned PHASE_BEATS  = 90;
  localparam int unsigned BURST_BEATS  = 200;

  logic clk_i;
  logic rst_ni;

  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [8:0]           cfg_data_i;

  logic                 in_valid_i;
  logic                 in_ready_o;
  csb_pix_in_t          in_data_i;

  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  csb_pix_out_t         out_data_o;

  // Local copy of the configuration registers, reset values included
  logic [2:0] cur_preset;
  logic [8:0] cur_weight;

  csb_pix_out_t blended_q[$];
  int unsigned  mismatch_count = 0;
  int unsigned  result_count = 0;
  int unsigned  cycle_count = 0;
  bit           idle_off;

  color_style_preset_blend_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // -------------------------------------------------------------------------
  // Clock and cycle limit
  // -------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Abandon the run if the pipeline hangs or starves
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_color_style_preset_blend_core: FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  // Mix one channel: in*256*(256-w) + styled*w in 1/65536 steps, round half
  // up, clip at 510.
  function automatic logic [8:0] mix_chan(int unsigned pix, int unsigned styled,
                                          int unsigned w);
    longint unsigned acc;
    longint unsigned res;
    acc = longint'(pix) * K_UNITY * (K_UNITY - w) + longint'(styled) * w;
    res = (acc + 32768) >> 16;
    if (res > K_CLIP) res = K_CLIP;
    return res[8:0];
  endfunction

  function automatic csb_pix_out_t blend_pixel(csb_pix_in_t px, logic [2:0] preset,
                                               logic [8:0] weight);
    int unsigned  r, g, b, sr, sg, sb, w, lum;
    csb_pix_out_t res;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    case (preset)
      PRESET_WARM: begin
        sr = r * K_1P3; sg = g * K_0P7; sb = b * K_1P4;
      end
      PRESET_ROTATE: begin
        sr = b * K_UNITY; sg = r * K_UNITY; sb = g * K_UNITY;
      end
      PRESET_COOL: begin
        sr = r * K_0P5; sg = g * K_0P9; sb = b * K_1P5;
      end
      PRESET_SWAP: begin
        sr = g * K_1P2; sg = r * K_0P8; sb = b * K_0P9;
      end
      PRESET_VIVID: begin
        sr = r * K_1P5 + K_OFS_TENTH;
        sg = g * K_0P2;
        sb = b * K_1P8 + K_OFS_FIFTH;
      end
      PRESET_GREY: begin
        lum = r * K_LUM_R + g * K_LUM_G + b * K_LUM_B;
        sr = lum; sg = lum; sb = lum;
      end
      default: begin
        sr = r * K_UNITY; sg = g * K_UNITY; sb = b * K_UNITY;
      end
    endcase
    // Weights above unity clamp to the full styled colour
    w = (weight > K_UNITY) ? K_UNITY : weight;
    res.red_out   = mix_chan(r, sr, w);
    res.green_out = mix_chan(g, sg, w);
    res.blue_out  = mix_chan(b, sb, w);
    res.alpha_out = px.alpha_in;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Stall the result channel at random unless a no-idle stretch is running
  always @(negedge clk_i) begin
    out_ready_i <= idle_off ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every accepted result beat against the oldest prediction
  always @(posedge clk_i) begin
    csb_pix_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blended_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing pending", result_count));
      end else begin
        want = blended_q.pop_front();
        if (out_data_o.red_out !== want.red_out)
          report_mismatch($sformatf("beat %0d red_out got %0d want %0d",
                                    result_count, out_data_o.red_out, want.red_out));
        if (out_data_o.green_out !== want.green_out)
          report_mismatch($sformatf("beat %0d green_out got %0d want %0d",
                                    result_count, out_data_o.green_out, want.green_out));
        if (out_data_o.blue_out !== want.blue_out)
          report_mismatch($sformatf("beat %0d blue_out got %0d want %0d",
                                    result_count, out_data_o.blue_out, want.blue_out));
        if (out_data_o.alpha_out !== want.alpha_out)
          report_mismatch($sformatf("beat %0d alpha_out got %0d want %0d",
                                    result_count, out_data_o.alpha_out, want.alpha_out));
      end
      result_count++;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  // Send one pixel beat. Idle each cycle at random first, then hold valid and
  // data until the core takes the beat; predict the result at the accepting
  // edge.
  task automatic send_pixel(csb_pix_in_t px);
    while (!idle_off && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    blended_q.push_back(blend_pixel(px, cur_preset, cur_weight));
  endtask

  function automatic csb_pix_in_t make_pixel(int unsigned r, int unsigned g,
                                             int unsigned b, int unsigned a);
    csb_pix_in_t px;
    px.red_in   = r[7:0];
    px.green_in = g[7:0];
    px.blue_in  = b[7:0];
    px.alpha_in = a[7:0];
    return px;
  endfunction

  // Random channel: uniform half the time, otherwise at or near an end of the range
  function automatic int unsigned rand_chan();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 3);
      3:       return $urandom_range(252, 255);
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic int unsigned rand_weight();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return 255;
      3:       return 256;
      4:       return 257;
      5:       return 511;
      default: return $urandom_range(511);
    endcase
  endfunction

  // Drop valid, wait for every pending result, then allow the pipeline to
  // empty out completely before the configuration is touched.
  task automatic settle_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // One configuration beat; the local copy follows at the accepting edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IDX_PRESET) cur_preset = data[2:0];
    else if (idx == CFG_IDX_WEIGHT) cur_weight = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_style(logic [2:0] preset, logic [8:0] weight);
    settle_pipeline();
    write_reg(CFG_IDX_PRESET, {6'd0, preset});
    write_reg(CFG_IDX_WEIGHT, weight);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Reset values alone: warm preset at full weight, no write yet
  task automatic test_reset_defaults();
    send_pixel(make_pixel(255, 255, 255, 255));
    send_pixel(make_pixel(0, 0, 0, 0));
  endtask

  // Every preset at full weight, on white (no channel exceeds the clip at 510) and
  // on a mixed pixel that tells the channels apart
  task automatic test_each_preset();
    for (int p = 0; p < 8; p++) begin
      set_style(p[2:0], 9'd256);
      send_pixel(make_pixel(255, 255, 255, 8'hA5));
      send_pixel(make_pixel(255, 1, 128, 8'h5A));
    end
  endtask

  // Weight clamping above unity, zero weight, and the pass-through code seven
  task automatic test_weight_edges();
    set_style(PRESET_VIVID, 9'd511);
    send_pixel(make_pixel(200, 100, 255, 1));
    set_style(PRESET_VIVID, 9'd257);
    send_pixel(make_pixel(200, 100, 255, 2));
    set_style(PRESET_GREY, 9'd0);
    send_pixel(make_pixel(255, 0, 17, 128));
    set_style(PRESET_PASS_B, 9'd511);
    send_pixel(make_pixel(254, 1, 127, 254));
  endtask

  // A write to an unused index must leave both registers as they were
  task automatic test_unused_index();
    set_style(PRESET_SWAP, 9'd128);
    write_reg(CFG_IDX_SPARE, 9'd511);
    send_pixel(make_pixel(255, 255, 0, 77));
  endtask

  // Random phases: presets in turn first, then any preset, weights biased
  // towards the ends of their range and around unity
  task automatic test_random_phases();
    logic [2:0] preset;
    for (int ph = 0; ph < 14; ph++) begin
      preset = (ph < 8) ? ph[2:0] : 3'($urandom_range(7));
      set_style(preset, 9'(rand_weight()));
      repeat (PHASE_BEATS)
        send_pixel(make_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(255)));
    end
  endtask

  // Full-rate stretch: neither side idles, so the queue runs back to back
  task automatic test_full_rate_burst();
    set_style(PRESET_PASS_A - 3'(1 + $urandom_range(5)), 9'(rand_weight()));
    idle_off = 1'b1;
    repeat (BURST_BEATS)
      send_pixel(make_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(255)));
    settle_pipeline();
    idle_off = 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cur_preset     = PRESET_WARM;
    cur_weight     = 9'd256;
    idle_off       = 1'b0;

    // Hold reset, then release it away from the rising edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_each_preset();
    test_weight_edges();
    test_unused_index();
    test_random_phases();
    test_full_rate_burst();

    // Drain everything still in flight and wait out the pipeline slack, so that
    // any stray beat shows
    settle_pipeline();

    if (mismatch_count == 0) begin
      $display("tb_color_style_preset_blend_core: PASS");
    end else begin
      $display("tb_color_style_preset_blend_core: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/csb_pkg.sv
hdl/csb_front.sv
hdl/csb_queue.sv
hdl/csb_back.sv
hdl/color_style_preset_blend_core.sv
bench/tb_color_style_preset_blend_core.sv
